// File: rtl/core/jac_pkg.sv
package jac_pkg;

	localparam int AXIS_W = 16;
	localparam int RES_W  = AXIS_W + 1;
	localparam int BTN_W  = 8;
	localparam int CFG_W  = 32;
	localparam int IDX_W  = 3;

	// Divider sequencing: one quotient bit per step.
	localparam int DIV_STEPS = AXIS_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_X_LIMITS   = 3'd0;
	localparam logic [IDX_W-1:0] REG_Y_LIMITS   = 3'd1;
	localparam logic [IDX_W-1:0] REG_X_CENTRE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_Y_CENTRE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_X_SCALES   = 3'd4;
	localparam logic [IDX_W-1:0] REG_Y_SCALES   = 3'd5;
	localparam logic [IDX_W-1:0] REG_DEAD_ZONES = 3'd6;
	localparam logic [IDX_W-1:0] REG_FAILURE    = 3'd7;

	// Reset values.
	localparam logic [CFG_W-1:0]  RST_LIMITS  = 32'hFFFF_0000;
	localparam logic [AXIS_W-1:0] RST_CENTRE  = 16'h8000;
	localparam logic [CFG_W-1:0]  RST_SCALES  = 32'h0001_0001;
	localparam logic [CFG_W-1:0]  RST_DEAD    = 32'h0000_0000;
	localparam logic [AXIS_W-1:0] RST_FAILURE = 16'hFFFF;

	typedef logic [AXIS_W-1:0] axis_t;
	typedef logic signed [RES_W-1:0] res_t;

endpackage

// File: rtl/core/jac_div.sv
module jac_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  jac_pkg::axis_t dividend,
	input  jac_pkg::axis_t divisor,
	output logic          done,
	output jac_pkg::axis_t quotient
);
	import jac_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	axis_t                q_q;
	axis_t                r_q;
	axis_t                d_q;

	logic [AXIS_W:0] rem_shift;
	logic            fits;
	logic [AXIS_W:0] rem_sub;

	// Restoring division: the dividend shifts out of q_q one bit per cycle while
	// the quotient bits shift in behind it.
	always_comb begin
		rem_shift = {r_q, q_q[AXIS_W-1]};
		fits      = rem_shift >= {1'b0, d_q};
		rem_sub   = rem_shift - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[AXIS_W-2:0], fits};
			r_q <= fits ? rem_sub[AXIS_W-1:0] : rem_shift[AXIS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

// File: rtl/core/joystick_axis_calibrator_core.sv
// Calibrates one raw two-axis joystick sample per transaction into signed
// axis values with dead zone, plus the buttons and a valid flag. A read error
// or a raw axis equal to failure_value makes the device inactive until reset;
// that sample and all later ones give zeros with valid_res clear. An active
// sample is worked one axis at a time: ST_PREP picks the operands and starts
// the divider if one is needed, ST_WAIT takes the quotient into the axis
// result register, and after the second axis ST_DONE moves the result to the
// output register. Both axes share one radix-2 divider that produces a
// quotient bit per cycle. An axis at the centre or on a zero-scale side skips
// the divider. An inactive sample goes from ST_IDLE straight to ST_DONE. A
// result waits in ST_DONE while the output register holds a stalled result.
// One sample is processed at a time; the next one is accepted as soon as the
// previous result has moved to the output register.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while no sample is in flight.
module joystick_axis_calibrator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [jac_pkg::AXIS_W-1:0]    raw_x,
	input  logic [jac_pkg::AXIS_W-1:0]    raw_y,
	input  logic [jac_pkg::BTN_W-1:0]     raw_buttons,
	input  logic                          read_error,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [jac_pkg::RES_W-1:0] axis_x,
	output logic signed [jac_pkg::RES_W-1:0] axis_y,
	output logic [jac_pkg::BTN_W-1:0]     buttons,
	output logic                          valid_res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [jac_pkg::IDX_W-1:0]     cfg_index,
	input  logic [jac_pkg::CFG_W-1:0]     cfg_data
);
	import jac_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	// Configuration registers.
	logic [CFG_W-1:0] x_limits_q;
	logic [CFG_W-1:0] y_limits_q;
	axis_t            x_centre_q;
	axis_t            y_centre_q;
	logic [CFG_W-1:0] x_scales_q;
	logic [CFG_W-1:0] y_scales_q;
	logic [CFG_W-1:0] dead_zones_q;
	axis_t            failure_q;

	logic       device_active_q;
	logic [1:0] state_q;
	logic       axis_sel_q;
	logic       live_q;
	axis_t      raw_x_q;
	axis_t      raw_y_q;
	logic [BTN_W-1:0] btn_q;
	res_t       ax_q;
	res_t       ay_q;

	logic             out_valid_q;
	res_t             out_x_q;
	res_t             out_y_q;
	logic [BTN_W-1:0] out_btn_q;
	logic             out_vres_q;

	logic sample_take;
	logic sample_fail;
	logic out_free;

	logic [CFG_W-1:0] lim;
	logic [CFG_W-1:0] scl;
	axis_t            centre;
	axis_t            dz;
	axis_t            raw_v;
	axis_t            clamped;
	axis_t            lo_div;
	axis_t            hi_div;
	logic             low_side;
	logic             use_low;
	logic             use_high;
	axis_t            offset;
	axis_t            divisor;
	res_t             axis_res;

	logic  div_start;
	logic  div_done;
	axis_t quot;

	assign cfg_ready    = 1'b1;
	assign sample_stall = state_q != ST_IDLE;
	assign sample_take  = sample_valid && !sample_stall;
	assign sample_fail  = read_error || raw_x == failure_q || raw_y == failure_q;
	assign out_free     = !out_valid_q || !result_stall;

	// Operand selection and clamping for the working axis. The raw sample holds
	// still while the divider runs; the user must keep the configuration still, the block does not.
	always_comb begin
		lim     = axis_sel_q ? y_limits_q : x_limits_q;
		scl     = axis_sel_q ? y_scales_q : x_scales_q;
		centre  = axis_sel_q ? y_centre_q : x_centre_q;
		dz      = axis_sel_q ? dead_zones_q[CFG_W-1:AXIS_W] : dead_zones_q[AXIS_W-1:0];
		raw_v   = axis_sel_q ? raw_y_q : raw_x_q;
		clamped = raw_v;
		if (clamped < lim[AXIS_W-1:0]) begin
			clamped = lim[AXIS_W-1:0];
		end
		if (clamped > lim[CFG_W-1:AXIS_W]) begin
			clamped = lim[CFG_W-1:AXIS_W];
		end
		lo_div   = scl[AXIS_W-1:0];
		hi_div   = scl[CFG_W-1:AXIS_W];
		low_side = clamped < centre;
		use_low  = low_side && lo_div != '0;
		use_high = clamped > centre && hi_div != '0;
		offset   = low_side ? centre - clamped : clamped - centre;
		divisor  = low_side ? lo_div : hi_div;
		if (quot > dz) begin
			axis_res = low_side ? RES_W'(0) - res_t'({1'b0, quot}) : res_t'({1'b0, quot});
		end else begin
			axis_res = '0;
		end
	end

	assign div_start = state_q == ST_PREP && (use_low || use_high);

	jac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (offset),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limits_q   <= RST_LIMITS;
			y_limits_q   <= RST_LIMITS;
			x_centre_q   <= RST_CENTRE;
			y_centre_q   <= RST_CENTRE;
			x_scales_q   <= RST_SCALES;
			y_scales_q   <= RST_SCALES;
			dead_zones_q <= RST_DEAD;
			failure_q    <= RST_FAILURE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_LIMITS:   x_limits_q   <= cfg_data;
				REG_Y_LIMITS:   y_limits_q   <= cfg_data;
				REG_X_CENTRE:   x_centre_q   <= cfg_data[AXIS_W-1:0];
				REG_Y_CENTRE:   y_centre_q   <= cfg_data[AXIS_W-1:0];
				REG_X_SCALES:   x_scales_q   <= cfg_data;
				REG_Y_SCALES:   y_scales_q   <= cfg_data;
				REG_DEAD_ZONES: dead_zones_q <= cfg_data;
				REG_FAILURE:    failure_q    <= cfg_data[AXIS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			device_active_q <= 1'b1;
			axis_sel_q      <= 1'b0;
			live_q          <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			// In ST_DONE the output register is reloaded below instead.
			if (out_valid_q && !result_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_take) begin
						live_q          <= device_active_q && !sample_fail;
						device_active_q <= device_active_q && !sample_fail;
						axis_sel_q      <= 1'b0;
						state_q         <= (device_active_q && !sample_fail) ? ST_PREP : ST_DONE;
					end
				end
				ST_PREP: begin
					if (use_low || use_high) begin
						state_q <= ST_WAIT;
					end else if (axis_sel_q) begin
						state_q <= ST_DONE;
					end else begin
						axis_sel_q <= 1'b1;
					end
				end
				ST_WAIT: begin
					if (div_done) begin
						if (axis_sel_q) begin
							state_q <= ST_DONE;
						end else begin
							axis_sel_q <= 1'b1;
							state_q    <= ST_PREP;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample_take) begin
			raw_x_q <= raw_x;
			raw_y_q <= raw_y;
			btn_q   <= raw_buttons;
		end
		if (state_q == ST_PREP && !(use_low || use_high)) begin
			if (axis_sel_q) begin
				ay_q <= '0;
			end else begin
				ax_q <= '0;
			end
		end
		if (state_q == ST_WAIT && div_done) begin
			if (axis_sel_q) begin
				ay_q <= axis_res;
			end else begin
				ax_q <= axis_res;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_x_q    <= live_q ? ax_q : '0;
			out_y_q    <= live_q ? ay_q : '0;
			out_btn_q  <= live_q ? btn_q : '0;
			out_vres_q <= live_q;
		end
	end

	assign result_valid = out_valid_q;
	assign axis_x       = out_x_q;
	assign axis_y       = out_y_q;
	assign buttons      = out_btn_q;
	assign valid_res    = out_vres_q;

endmodule
